@@ rtl/fifo_page_replacement_unit_assert.svh @@
// Assertion macros for the page replacement unit
`ifndef FIFO_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FPRU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define FPRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fpru_pkg.sv @@
package fpru_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_W      = 4;
	localparam int FAULT_W    = 16;
	localparam int FIDX_W     = 3;
	localparam int EPAGE_W    = 8;

	localparam logic [CFG_W-1:0]   CFG_RESET = 4'd4;
	localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last_issue;
		logic out_free;
	} status_t;

endpackage

@@ rtl/fpru_ctrl.sv @@
module fpru_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  fpru_pkg::status_t sts,
	output fpru_pkg::cmd_t   cmd,
	output fpru_pkg::state_t state
);

	fpru_pkg::state_t state_q;
	fpru_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpru_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		s_tready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			fpru_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_nxt = fpru_pkg::ST_SCAN;
				end
			end
			fpru_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last_issue) begin
					state_nxt = fpru_pkg::ST_DRAIN;
				end
			end
			fpru_pkg::ST_DRAIN: begin
				state_nxt = fpru_pkg::ST_COMMIT;
			end
			fpru_pkg::ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = fpru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = fpru_pkg::ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

@@ rtl/fpru_dp.sv @@
module fpru_dp #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 8,
	parameter int AGE_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fpru_pkg::cmd_t                    cmd,
	input  logic                              cfg_we,
	input  logic [fpru_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic [fpru_pkg::IN_DATA_W-1:0]    in_page,
	output fpru_pkg::status_t                 sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fpru_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

	logic [PAGE_BITS-1:0] page_mem [FRAMES];
	logic [AGE_BITS-1:0]  age_mem  [FRAMES];
	logic [FRAMES-1:0]    valid_q;

	logic [fpru_pkg::CFG_W-1:0] frames_in_use_q;
	logic [PAGE_BITS-1:0]       page_q;
	logic [IDX_W-1:0]           last_idx_q;
	logic [IDX_W-1:0]           rd_idx_q;

	logic                 vld_s1;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic [AGE_BITS-1:0]  age_s1;

	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 empty_q;
	logic [IDX_W-1:0]     empty_idx_q;
	logic [IDX_W-1:0]     max_idx_q;
	logic [AGE_BITS-1:0]  max_age_q;
	logic [PAGE_BITS-1:0] max_page_q;

	logic [fpru_pkg::FAULT_W-1:0] faults_q;
	logic [fpru_pkg::FAULT_W-1:0] faults_nxt;

	logic                                 m_tvalid_q;
	logic [fpru_pkg::OUT_DATA_W-1:0]      m_tdata_q;

	logic [PAGE_BITS+fpru_pkg::IN_DATA_W-1:0] in_page_ext;
	logic [fpru_pkg::CFG_W-1:0]               cfg_m1;
	logic [31:0]                              cfg_m1_ext;
	logic [IDX_W-1:0]                         last_idx;
	logic [IDX_W-1:0]                         slot;
	logic [IDX_W+fpru_pkg::FIDX_W-1:0]        slot_ext;
	logic                                     evicted;
	logic [PAGE_BITS+fpru_pkg::EPAGE_W-1:0]   ev_page_ext;
	logic [fpru_pkg::EPAGE_W-1:0]             ev_page;
	logic [AGE_BITS-1:0]                      age_inc;
	logic [fpru_pkg::OUT_DATA_W-1:0]          result;

	assign in_page_ext = {{PAGE_BITS{1'b0}}, in_page};
	assign cfg_m1      = frames_in_use_q - fpru_pkg::CFG_W'(1);
	assign cfg_m1_ext  = 32'(cfg_m1);

	always_comb begin
		if (frames_in_use_q == '0) begin
			last_idx = '0;
		end else if (32'(frames_in_use_q) > 32'(FRAMES)) begin
			last_idx = LAST_IDX;
		end else begin
			last_idx = cfg_m1_ext[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= fpru_pkg::CFG_RESET;
		end else if (cfg_we) begin
			frames_in_use_q <= cfg_wdata;
		end
	end

	// request capture and scan address
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q     <= in_page_ext[PAGE_BITS-1:0];
			last_idx_q <= last_idx;
			rd_idx_q   <= '0;
		end else if (cmd.scan) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	assign sts.last_issue = (rd_idx_q == last_idx_q);
	assign sts.out_free   = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		valid_s1 <= valid_q[rd_idx_q];
		idx_s1   <= rd_idx_q;
		page_s1  <= page_mem[rd_idx_q];
	end

	assign age_inc = (age_s1 == '1) ? age_s1 : age_s1 + AGE_BITS'(1);

	// age memory: read at the scan address, written by the aging scan or the load
	always_ff @(posedge clk) begin
		age_s1 <= age_mem[rd_idx_q];
		if (vld_s1 && valid_s1) begin
			age_mem[idx_s1] <= age_inc;
		end else if (cmd.commit && !hit_q) begin
			age_mem[slot] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_q) begin
			page_mem[slot] <= page_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (vld_s1) begin
			if (valid_s1 && page_s1 == page_q && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (!valid_s1 && !empty_q) begin
				empty_q     <= 1'b1;
				empty_idx_q <= idx_s1;
			end
			if (idx_s1 == '0 || age_s1 > max_age_q) begin
				max_idx_q  <= idx_s1;
				max_age_q  <= age_s1;
				max_page_q <= page_s1;
			end
		end
	end

	assign slot    = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : max_idx_q);
	assign evicted = !hit_q && !empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && !hit_q) begin
			valid_q[slot] <= 1'b1;
		end
	end

	always_comb begin
		faults_nxt = faults_q;
		if (!hit_q && faults_q != fpru_pkg::FAULT_MAX) begin
			faults_nxt = faults_q + fpru_pkg::FAULT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faults_q <= '0;
		end else if (cmd.commit) begin
			faults_q <= faults_nxt;
		end
	end

	assign slot_ext    = {{fpru_pkg::FIDX_W{1'b0}}, slot};
	assign ev_page_ext = {{fpru_pkg::EPAGE_W{1'b0}}, max_page_q};
	assign ev_page     = evicted ? ev_page_ext[fpru_pkg::EPAGE_W-1:0] : '0;

	assign result = {3'b000, faults_nxt, ev_page, evicted,
		slot_ext[fpru_pkg::FIDX_W-1:0], hit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/fifo_page_replacement_unit.sv @@
// FIFO page replacement unit. Each request on the slave stream is one page
// reference; one result per reference comes out on the master stream. The
// frames taking part are set by the 4-bit frames_in_use register (0 acts as
// 1, values above FRAMES act as FRAMES); the user must write it only while
// idle, the block does not enforce this. Page and age memories are scanned
// one frame per cycle, then a drain state drains the registered read and a
// commit state commits the load and loads the output register. Commit waits
// while the output register holds a result not yet taken by m_tready. The
// next request is taken the cycle after commit, even while the previous
// result still waits on m_tready; no new request is accepted before the
// previous one has been committed.
module fifo_page_replacement_unit #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 8,
	parameter int AGE_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fpru_pkg::CFG_W-1:0]      cfg_wdata,    // frames_in_use
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fpru_pkg::IN_DATA_W-1:0]  s_tdata,      // [7:0] page
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] hit, [3:1] frame_index, [4] evicted_valid, [12:5] evicted_page,
	// [28:13] fault_count, [31:29] zero
	output logic [fpru_pkg::OUT_DATA_W-1:0] m_tdata
);

	`include "fifo_page_replacement_unit_assert.svh"

	fpru_pkg::cmd_t    cmd;
	fpru_pkg::status_t sts;
	fpru_pkg::state_t  state;

	fpru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	fpru_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.AGE_BITS  (AGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_page   (s_tdata),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`FPRU_ASSERT_NEXT(a_no_accept_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "request accepted while previous one in flight")
	`FPRU_ASSERT_SAME(a_commit_needs_room, clk, arst_n, cmd.commit, sts.out_free, "commit with output register occupied")
	`FPRU_ASSERT_SAME(a_result_from_commit, clk, arst_n, $rose(m_tvalid), $past(state) == fpru_pkg::ST_COMMIT, "result appeared without commit")

endmodule
